[hw/rtl/ccc_pkg.sv]
// Package for the complex cross-correlator: operation and status codes, widths.
// No dependencies.
package ccc_pkg;
    localparam int unsigned MAX_SAMPLES_DEF = 4096;
    localparam int unsigned ENERGY_W = 44;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned MAG_W    = 24;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO_E  = 2'd1,
        ST_BAD_LAG = 2'd2
    } t_status;
endpackage

[hw/rtl/ccc_sqdiv.sv]
// Iterative square root of a 128-bit value followed by an unsigned division.
// Depends on ccc_pkg.
module ccc_sqdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [127:0]                  i_radicand,
    input  logic [ccc_pkg::ENERGY_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [ccc_pkg::MAG_W-1:0]     o_quot
);
    import ccc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROOT = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [127:0]  r_rem;      // root remainder
    logic [127:0]  r_rad;      // radicand, shifted two bits a step
    logic [63:0]   r_root;
    logic [6:0]    r_cnt;
    logic [ENERGY_W-1:0] r_div;
    logic [64:0]   r_drem;
    logic [63:0]   r_quo;
    logic [129:0]  w_trial_rem;
    logic [129:0]  w_trial_sub;
    logic [64:0]   w_dshift;

    // restoring root, two radicand bits per step
    assign w_trial_rem = {r_rem, r_rad[127:126]};
    assign w_trial_sub = {64'd0, r_root, 2'b01};
    // restoring divide, one quotient bit per step
    assign w_dshift = {r_drem[63:0], r_root[r_cnt[5:0]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem  <= '0;
                        r_rad  <= i_radicand;
                        r_root <= '0;
                        r_div  <= i_divisor;
                        r_cnt  <= 7'd63;
                    end
                end
                S_ROOT: begin
                    r_rad <= {r_rad[125:0], 2'b00};
                    if (w_trial_rem >= w_trial_sub) begin
                        r_rem  <= 128'(w_trial_rem - w_trial_sub);
                        r_root <= {r_root[62:0], 1'b1};
                    end else begin
                        r_rem  <= 128'(w_trial_rem);
                        r_root <= {r_root[62:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_cnt  <= 7'd63;
                        r_drem <= '0;
                        r_quo  <= '0;
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_DIV: begin
                    if (w_dshift >= {21'd0, r_div}) begin
                        r_drem <= w_dshift - {21'd0, r_div};
                        r_quo  <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_drem <= w_dshift;
                        r_quo  <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_ROOT;
            S_ROOT: if (r_cnt == '0) n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [63:0] w_q_final;
    assign w_q_final = {r_quo[62:0], (w_dshift >= {21'd0, r_div})};
    assign o_done = (r_state == S_DIV) && (r_cnt == '0);
    assign o_quot = (w_q_final[63:MAG_W] != '0) ? {MAG_W{1'b1}} : w_q_final[MAG_W-1:0];
endmodule

[hw/rtl/complex_cross_correlator.sv]
// Normalized complex cross-correlator top level: sample stores, MAC, control.
// Depends on ccc_pkg and ccc_sqdiv.
// Load and clear: input ready again on the next cycle after acceptance.
// Query: (count - lag) sample-pair reads, drain, squaring on one 24x24 multiplier,
// a start pulse, 64 root and 64 divide steps; result valid after the last divide
// step. Out-of-range or zero-energy query: valid next cycle.
// Input ready again the cycle after the result transaction. Synchronous active-low
// reset clears count, energy and control; memories are not cleared.
module complex_cross_correlator #(
    parameter int unsigned MAX_SAMPLES = ccc_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // ref_i, ref_q, data_i, data_q, lag, 4'b0
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // magnitude
    output logic [1:0]  m_axis_tuser   // status
);
    import ccc_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_DRN  = 6'b000100,
        S_SQ   = 6'b001000,
        S_ROOT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    logic [CW-1:0]       r_count;
    logic [ENERGY_W-1:0] r_energy;
    logic [31:0] r_ref_mem [MAX_SAMPLES];
    logic [31:0] r_dat_mem [MAX_SAMPLES];
    logic [31:0] r_ref_rd, r_dat_rd;
    logic [CW-1:0] r_n, r_lag;
    logic        r_rd_vld;
    logic signed [ACC_W-1:0] r_re, r_im;
    logic signed [32:0] r_pre, r_pim;
    logic        r_p_vld;
    logic [MAG_W-1:0] r_mag;
    logic [1:0]  r_status;
    logic        r_start;
    logic [127:0] r_rad;
    logic [95:0] r_sq;
    logic [2:0]  r_sq_step;

    logic [1:0]  w_op;
    logic signed [15:0] w_ri, w_rq, w_di, w_dq;
    logic [11:0] w_lag;
    logic        w_in_acc;
    logic [CW-1:0] w_didx;
    logic        w_done;
    logic [MAG_W-1:0] w_quot;

    assign w_op  = s_axis_tuser;
    assign w_ri  = s_axis_tdata[15:0];
    assign w_rq  = s_axis_tdata[31:16];
    assign w_di  = s_axis_tdata[47:32];
    assign w_dq  = s_axis_tdata[63:48];
    assign w_lag = s_axis_tdata[75:64];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_didx = r_n + r_lag;

    // sample memories, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == OP_LOAD && r_count < CW'(MAX_SAMPLES)) begin
            r_ref_mem[r_count[AW-1:0]] <= {w_ri, w_rq};
            r_dat_mem[r_count[AW-1:0]] <= {w_di, w_dq};
        end
        r_ref_rd <= r_ref_mem[r_n[AW-1:0]];
        r_dat_rd <= r_dat_mem[w_didx[AW-1:0]];
    end

    logic signed [15:0] w_mri, w_mrq, w_mdi, w_mdq;
    logic [ACC_W-1:0] w_are, w_aim;
    logic [ACC_W-1:0] w_sq_src;
    logic [23:0] w_mx, w_my;
    logic [47:0] w_mp;
    logic [95:0] w_term;
    logic [95:0] w_sq_next;
    assign w_mri = r_ref_rd[31:16];
    assign w_mrq = r_ref_rd[15:0];
    assign w_mdi = r_dat_rd[31:16];
    assign w_mdq = r_dat_rd[15:0];
    assign w_are = r_re[ACC_W-1] ? ACC_W'(-r_re) : r_re;
    assign w_aim = r_im[ACC_W-1] ? ACC_W'(-r_im) : r_im;

    // |C|^2 from 24-bit halves: lo*lo, then 2*hi*lo, then hi*hi, for re then im
    always_comb begin
        w_sq_src = (r_sq_step >= 3'd3) ? w_aim : w_are;
        case (r_sq_step) inside
            3'd0, 3'd3: begin
                w_mx = w_sq_src[23:0];
                w_my = w_sq_src[23:0];
            end
            3'd1, 3'd4: begin
                w_mx = w_sq_src[ACC_W-1:24];
                w_my = w_sq_src[23:0];
            end
            default: begin
                w_mx = w_sq_src[ACC_W-1:24];
                w_my = w_sq_src[ACC_W-1:24];
            end
        endcase
    end

    assign w_mp = w_mx * w_my;

    always_comb begin
        case (r_sq_step) inside
            3'd0, 3'd3: w_term = 96'(w_mp);
            3'd1, 3'd4: w_term = 96'(w_mp) << 25;
            default:    w_term = 96'(w_mp) << 48;
        endcase
    end

    assign w_sq_next = r_sq + w_term;

    ccc_sqdiv u_sqdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_radicand (r_rad),
        .i_divisor  (r_energy),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_energy <= '0;
            r_rd_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_op)
                            OP_LOAD: begin
                                if (r_count < CW'(MAX_SAMPLES)) begin
                                    r_count  <= r_count + CW'(1);
                                    r_energy <= r_energy + ENERGY_W'(32'(w_ri * w_ri))
                                                         + ENERGY_W'(32'(w_rq * w_rq));
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_energy <= '0;
                            end
                            OP_QUERY: begin
                                r_lag <= CW'(w_lag);
                                r_n   <= '0;
                                r_re  <= '0;
                                r_im  <= '0;
                                r_mag <= '0;
                                if (32'(w_lag) >= 32'(r_count)) begin
                                    r_status <= ST_BAD_LAG;
                                    r_state  <= S_OUT;
                                end else if (r_energy == '0) begin
                                    r_status <= ST_ZERO_E;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_MAC;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    // issue reads until the data index reaches the count
                    r_rd_vld <= 1'b1;
                    r_n <= r_n + CW'(1);
                    if (w_didx + CW'(1) >= r_count) r_state <= S_DRN;
                end
                S_DRN: begin
                    r_rd_vld <= 1'b0;
                    if (!r_rd_vld && !r_p_vld) begin
                        r_sq      <= '0;
                        r_sq_step <= '0;
                        r_state   <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq      <= w_sq_next;
                    r_sq_step <= r_sq_step + 3'd1;
                    if (r_sq_step == 3'd5) begin
                        r_rad   <= {w_sq_next, 32'd0};
                        r_start <= 1'b1;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_done) begin
                        r_mag   <= w_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // product stage then accumulate
            r_p_vld <= r_rd_vld;
            if (r_rd_vld) begin
                r_pre <= 33'(32'(w_mdi * w_mri)) + 33'(32'(w_mdq * w_mrq));
                r_pim <= 33'(32'(w_mdq * w_mri)) - 33'(32'(w_mdi * w_mrq));
            end
            if (r_p_vld) begin
                r_re <= r_re + ACC_W'(r_pre);
                r_im <= r_im + ACC_W'(r_pim);
            end
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_mag;
    assign m_axis_tuser  = r_status;
endmodule

[bench/complex_cross_correlator_chk.sv]
// Checker for the complex cross-correlator: watches both streams, predicts each
// query result from the accepted loads and clears, and counts mismatches. Uses ccc_pkg.
module complex_cross_correlator_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [79:0] i_in_data,   // ref_i, ref_q, data_i, data_q, lag, 4'b0
    input  logic [1:0]  i_in_user,   // operation
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,  // magnitude
    input  logic [1:0]  i_out_user,  // status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    import ccc_pkg::*;

    typedef struct packed {
        logic [23:0] magnitude;
        t_status     status;
    } t_corr_result;

    logic signed [15:0] ref_i_mem [MAX_SAMPLES_DEF];
    logic signed [15:0] ref_q_mem [MAX_SAMPLES_DEF];
    logic signed [15:0] dat_i_mem [MAX_SAMPLES_DEF];
    logic signed [15:0] dat_q_mem [MAX_SAMPLES_DEF];
    int unsigned        n_loaded;
    logic [43:0]        ref_energy;
    t_corr_result       corr_queue[$];

    assign o_pending = corr_queue.size();

    // floor(sqrt(v)) for a 128-bit value, one bit per step
    function automatic logic [63:0] root128(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_corr_result correlate(input logic [11:0] lag);
        t_corr_result       res;
        logic signed [63:0] acc_re;
        logic signed [63:0] acc_im;
        logic [63:0]        abs_re;
        logic [63:0]        abs_im;
        logic [127:0]       pow;
        logic [63:0]        quot;
        int unsigned        k;
        acc_re = 0;
        acc_im = 0;
        if (lag >= n_loaded) begin
            res.magnitude = '0;
            res.status = ST_BAD_LAG;
            return res;
        end
        if (ref_energy == 0) begin
            res.magnitude = '0;
            res.status = ST_ZERO_E;
            return res;
        end
        for (int unsigned n = 0; n + lag < n_loaded; n++) begin
            k = n + lag;
            acc_re += 64'(dat_i_mem[k]) * ref_i_mem[n] + 64'(dat_q_mem[k]) * ref_q_mem[n];
            acc_im += 64'(dat_q_mem[k]) * ref_i_mem[n] - 64'(dat_i_mem[k]) * ref_q_mem[n];
        end
        abs_re = acc_re < 0 ? -acc_re : acc_re;
        abs_im = acc_im < 0 ? -acc_im : acc_im;
        pow = 128'(abs_re) * abs_re + 128'(abs_im) * abs_im;
        quot = root128(pow << 32) / 64'(ref_energy);
        res.magnitude = quot > 64'hFFFFFF ? 24'hFFFFFF : quot[23:0];
        res.status = ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_corr_result got;
        t_corr_result want;
        if (!i_rst_n) begin
            n_loaded <= 0;
            ref_energy <= '0;
            o_fail_count <= 0;
            o_results_seen <= 0;
            corr_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                case (t_op'(i_in_user))
                    OP_LOAD: begin
                        if (n_loaded < MAX_SAMPLES_DEF) begin
                            ref_i_mem[n_loaded] = i_in_data[15:0];
                            ref_q_mem[n_loaded] = i_in_data[31:16];
                            dat_i_mem[n_loaded] = i_in_data[47:32];
                            dat_q_mem[n_loaded] = i_in_data[63:48];
                            ref_energy <= ref_energy
                                + 44'(32'($signed(i_in_data[15:0])) * $signed(i_in_data[15:0]))
                                + 44'(32'($signed(i_in_data[31:16])) * $signed(i_in_data[31:16]));
                            n_loaded <= n_loaded + 1;
                        end
                    end
                    OP_QUERY: corr_queue.push_back(correlate(i_in_data[75:64]));
                    OP_CLEAR: begin
                        n_loaded <= 0;
                        ref_energy <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.magnitude = i_out_data;
                got.status = t_status'(i_out_user);
                o_results_seen <= o_results_seen + 1;
                if (corr_queue.size() == 0) begin
                    $error("result with nothing expected: magnitude %0d status %0d",
                           got.magnitude, got.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = corr_queue.pop_front();
                    if (got.magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, actual %0d",
                               want.magnitude, got.magnitude);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/complex_cross_correlator_tb.sv]
// Testbench top for the complex cross-correlator: drives loads, queries and clears
// with random idling on both streams, and reports the checker's verdict.
// Depends on ccc_pkg, complex_cross_correlator and complex_cross_correlator_chk.
module complex_cross_correlator_tb;
    import ccc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // ref_i, ref_q, data_i, data_q, lag, 4'b0
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // magnitude
    logic [1:0]  m_axis_tuser;   // status
    int          fail_count;
    int          pending;
    int          results_seen;
    bit          calm;
    int          n_sent;
    int          n_queries;

    complex_cross_correlator uut (.*);

    complex_cross_correlator_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // receiver stalls at random in bursts while calm is clear
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 4);
            m_axis_tready <= 1'b0;
            repeat (stall - 1) @(posedge i_clk);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // present one transaction, hold it until accepted, then maybe idle
    task automatic send(input t_op op, input logic [15:0] ri, input logic [15:0] rq,
                        input logic [15:0] di, input logic [15:0] dq,
                        input logic [11:0] lag);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'b0, lag, dq, di, rq, ri};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (op == OP_QUERY) n_queries++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_rand();
        send(OP_LOAD, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
             12'($urandom));
    endtask

    task automatic query(input logic [11:0] lag);
        send(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), lag);
    endtask

    initial begin
        int len;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NONE;
        i_rst_n = 1'b0;
        calm = 0;
        n_sent = 0;
        n_queries = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, zero energy, extremes, lag edges, unused op
        query(12'd0);
        send(OP_LOAD, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 12'd0);
        query(12'd0);
        query(12'hFFF);
        send(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
        send(OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'd0);
        send(OP_LOAD, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 12'd0);
        send(OP_LOAD, 16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF, 12'd0);
        query(12'd0);
        query(12'd3);
        query(12'd4);
        send(OP_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 12'd0);
        query(12'd0);
        // tiny reference against big data saturates the magnitude
        send(OP_LOAD, 16'h0001, 16'h0000, 16'h7FFF, 16'h8000, 12'd0);
        send(OP_LOAD, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 12'd0);
        query(12'd0);
        query(12'd1);
        send(OP_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 12'd0);

        // random: short frames of loads followed by queries, with some noise
        while (n_sent < 140) begin
            len = $urandom_range(1, 12);
            for (int n = 0; n < len; n++) load_rand();
            repeat ($urandom_range(1, 4)) query(12'($urandom_range(0, len + 1)));
            if ($urandom_range(0, 5) == 0) query(12'($urandom));
            if ($urandom_range(0, 7) == 0) send(OP_NONE, 16'($urandom), 16'($urandom),
                                                16'($urandom), 16'($urandom), 12'($urandom));
            if ($urandom_range(0, 2) != 0)
                send(OP_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 12'd0);
            if (n_sent > 110) calm = 1;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("ran %0d transactions in, %0d queries, %0d results checked",
                 n_sent, n_queries, results_seen);
        $display("covered empty, zero-energy, saturating and random frames");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule

[complex_cross_correlator.f]
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_sqdiv.sv
hw/rtl/complex_cross_correlator.sv
bench/complex_cross_correlator_chk.sv
bench/complex_cross_correlator_tb.sv
